// ===== src/bit_plane_watermark_codec_top_defines.svh =====
// ---------------------------------------------------------------------------
// Bit-plane watermark codec assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BIT_PLANE_WATERMARK_CODEC_TOP_DEFINES_SVH
`define BIT_PLANE_WATERMARK_CODEC_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every rising edge outside reset.
`define BPWM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that an expression is never true outside reset.
`define BPWM_NEVER(label, clk, rst, expr, msg) \
  `BPWM_ASSERT(label, clk, rst, !(expr), msg)

`else

`define BPWM_ASSERT(label, clk, rst, prop, msg)
`define BPWM_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// ===== src/bpwm_pkg.sv =====
// ---------------------------------------------------------------------------
// Bit-plane watermark codec package
// Cursor type and fixed codes shared by the codec modules.
// ---------------------------------------------------------------------------
package bpwm_pkg;

  // Coordinate and dimension widths.
  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;

  // Largest image side the cursor can address.
  localparam int CURSOR_REACH = 4096;

  // Channel codes.
  localparam logic [1:0] CH_RED  = 2'd0;
  localparam logic [1:0] CH_BLUE = 2'd2;

  // Highest bit plane.
  localparam logic [2:0] LAST_PLANE = 3'd7;

  // Request codes.
  localparam logic REQ_EXTRACT = 1'b0;
  localparam logic REQ_EMBED   = 1'b1;

  // Configuration register indexes.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Register reset values.
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  // Position of one sample in the image.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [1:0]         channel;
    logic [2:0]         plane;
  } cursor_t;

endpackage

// ===== src/bit_plane_watermark_codec_top.sv =====
// ---------------------------------------------------------------------------
// Bit-plane watermark codec top level
// Input register, cursor and bit engine, result register, config registers.
// ---------------------------------------------------------------------------
// The codec takes one colour sample per cycle while in_stall is low, at the cursor
// it reports in next_x, next_y and next_channel, and returns one result item for
// each sample through the input register and then the result register. The
// sustained rate of one item per clock, when out_stall is low, is set by the cursor
// and bit-counter update, a feedback loop around the cursor registers. After the
// last sample of plane 7 every item comes back with overrun set and the
// sample unchanged until reset. Write image_width and image_height only
// while no item is in flight.
`include "bit_plane_watermark_codec_top_defines.svh"

module bit_plane_watermark_codec_top #(
  parameter int MAX_DIM = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration port
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [bpwm_pkg::DIM_W-1:0]   cfg_data,
  // Input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         req_type,
  input  logic [7:0]                   sample,
  input  logic [7:0]                   payload_byte,
  // Output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bpwm_pkg::COORD_W-1:0] pos_x,
  output logic [bpwm_pkg::COORD_W-1:0] pos_y,
  output logic [1:0]                   channel,
  output logic [2:0]                   plane,
  output logic [7:0]                   new_sample,
  output logic                         byte_valid,
  output logic [7:0]                   byte_out,
  output logic                         overrun,
  output logic [bpwm_pkg::COORD_W-1:0] next_x,
  output logic [bpwm_pkg::COORD_W-1:0] next_y,
  output logic [1:0]                   next_channel
);

  logic [bpwm_pkg::DIM_W-1:0] image_width;
  logic [bpwm_pkg::DIM_W-1:0] image_height;
  logic                       in_full;
  logic                       req_q;
  logic [7:0]                 sample_q;
  logic [7:0]                 payload_q;
  logic                       move;
  bpwm_pkg::cursor_t          cur;
  bpwm_pkg::cursor_t          cur_after;
  logic                       exhausted;
  logic [7:0]                 new_sample_c;
  logic                       byte_valid_c;
  logic [7:0]                 byte_out_c;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bpwm_pkg::WIDTH_RESET;
      image_height <= bpwm_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bpwm_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        bpwm_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // The held item moves on when the result register is free or drains.
  assign move     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !move;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_q     <= req_type;
      sample_q  <= sample;
      payload_q <= payload_byte;
    end
  end

  // Cursor walk.
  bpwm_cursor #(
    .MAX_DIM(MAX_DIM)
  ) u_cursor (
    .clk         (clk),
    .rst         (rst),
    .step        (move),
    .image_width (image_width),
    .image_height(image_height),
    .cur         (cur),
    .cur_after   (cur_after),
    .exhausted   (exhausted)
  );

  // Embed and extract.
  bpwm_bits u_bits (
    .clk         (clk),
    .rst         (rst),
    .step        (move),
    .exhausted   (exhausted),
    .plane       (cur.plane),
    .req_type    (req_q),
    .sample      (sample_q),
    .payload_byte(payload_q),
    .new_sample  (new_sample_c),
    .byte_valid  (byte_valid_c),
    .byte_out    (byte_out_c)
  );

  // Result register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (move) begin
      pos_x        <= cur.x;
      pos_y        <= cur.y;
      channel      <= cur.channel;
      plane        <= cur.plane;
      new_sample   <= new_sample_c;
      byte_valid   <= byte_valid_c;
      byte_out     <= byte_out_c;
      overrun      <= exhausted;
      next_x       <= cur_after.x;
      next_y       <= cur_after.y;
      next_channel <= cur_after.channel;
    end
  end

  // Overrun is sticky until reset.
  `BPWM_ASSERT(a_exhausted_sticky, clk, rst, exhausted |=> exhausted, "exhausted flag cleared")
  // A held item is neither lost nor altered.
  `BPWM_ASSERT(a_in_hold, clk, rst, in_stall |=> in_full && $stable(sample_q), "held item lost")
  // Every item that moves lands in the result register.
  `BPWM_ASSERT(a_move_lands, clk, rst, move |=> out_valid && (overrun == $past(exhausted)), "result not registered")
  // An overrun result never marks a byte.
  `BPWM_NEVER(a_overrun_byte, clk, rst, out_valid && overrun && byte_valid, "byte flagged on overrun")

endmodule

// ===== src/bpwm_cursor.sv =====
// ---------------------------------------------------------------------------
// Bit-plane watermark cursor
// Holds the sample cursor and the exhausted flag, and steps the cursor
// through channel, column, row and plane.
// ---------------------------------------------------------------------------
module bpwm_cursor #(
  parameter int MAX_DIM = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [bpwm_pkg::DIM_W-1:0] image_width,
  input  logic [bpwm_pkg::DIM_W-1:0] image_height,
  output bpwm_pkg::cursor_t          cur,
  output bpwm_pkg::cursor_t          cur_after,
  output logic                       exhausted
);

  localparam int DIM_LIMIT = (MAX_DIM > bpwm_pkg::CURSOR_REACH) ?
                             bpwm_pkg::CURSOR_REACH : MAX_DIM;
  localparam logic [bpwm_pkg::DIM_W-1:0] LIMIT = bpwm_pkg::DIM_W'(DIM_LIMIT);

  logic [bpwm_pkg::DIM_W-1:0]   width_eff;
  logic [bpwm_pkg::DIM_W-1:0]   height_eff;
  logic [bpwm_pkg::COORD_W-1:0] last_x;
  logic [bpwm_pkg::COORD_W-1:0] last_y;
  bpwm_pkg::cursor_t            cur_next;
  logic                         exhausted_next;

  // Clamp the dimensions to one at the low end and the limit at the top.
  always_comb begin
    width_eff = image_width;
    if (image_width == '0) begin
      width_eff = bpwm_pkg::DIM_W'(1);
    end else if (image_width > LIMIT) begin
      width_eff = LIMIT;
    end
    height_eff = image_height;
    if (image_height == '0) begin
      height_eff = bpwm_pkg::DIM_W'(1);
    end else if (image_height > LIMIT) begin
      height_eff = LIMIT;
    end
    last_x = bpwm_pkg::COORD_W'(width_eff - bpwm_pkg::DIM_W'(1));
    last_y = bpwm_pkg::COORD_W'(height_eff - bpwm_pkg::DIM_W'(1));
  end

  // Step to the next sample. A cursor at or past the last column or row
  // wraps as if it stood on the last one; channel code 3 acts as blue.
  always_comb begin
    cur_next       = cur;
    exhausted_next = 1'b0;
    if (cur.channel < bpwm_pkg::CH_BLUE) begin
      cur_next.channel = cur.channel + 2'd1;
    end else if (cur.x < last_x) begin
      cur_next.x       = cur.x + 1'b1;
      cur_next.channel = bpwm_pkg::CH_RED;
    end else if (cur.y < last_y) begin
      cur_next.x       = '0;
      cur_next.y       = cur.y + 1'b1;
      cur_next.channel = bpwm_pkg::CH_RED;
    end else if (cur.plane < bpwm_pkg::LAST_PLANE) begin
      cur_next.x       = '0;
      cur_next.y       = '0;
      cur_next.plane   = cur.plane + 3'd1;
      cur_next.channel = bpwm_pkg::CH_RED;
    end else begin
      exhausted_next = 1'b1;
    end
  end

  // Once exhausted the cursor holds still.
  always_comb begin
    cur_after = exhausted ? cur : cur_next;
  end

  // Cursor registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      exhausted <= 1'b0;
    end else if (step && !exhausted) begin
      cur       <= cur_next;
      exhausted <= exhausted_next;
    end
  end

endmodule

// ===== src/bpwm_bits.sv =====
// ---------------------------------------------------------------------------
// Bit-plane watermark bit engine
// Embeds a payload bit into the sample's plane, or gathers plane bits into
// bytes; counts bits modulo eight.
// ---------------------------------------------------------------------------
module bpwm_bits (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       exhausted,
  input  logic [2:0] plane,
  input  logic       req_type,
  input  logic [7:0] sample,
  input  logic [7:0] payload_byte,
  output logic [7:0] new_sample,
  output logic       byte_valid,
  output logic [7:0] byte_out
);

  logic [2:0] bit_index;
  logic [2:0] bit_index_next;
  logic [7:0] gathered_bits;
  logic [7:0] gathered_bits_next;
  logic       embed_bit;

  // Shift in the plane bit and pick the payload bit, MSB first.
  always_comb begin
    gathered_bits_next = {gathered_bits[6:0], sample[plane]};
    bit_index_next     = bit_index + 3'd1;
    embed_bit          = payload_byte[3'd7 - bit_index];
  end

  // Result fields; an exhausted cursor passes the sample through.
  always_comb begin
    new_sample = sample;
    byte_valid = 1'b0;
    byte_out   = '0;
    if (!exhausted) begin
      if (req_type == bpwm_pkg::REQ_EMBED) begin
        new_sample[plane] = embed_bit;
      end
      byte_valid = (bit_index_next == 3'd0);
      if (byte_valid && req_type == bpwm_pkg::REQ_EXTRACT) begin
        byte_out = gathered_bits_next;
      end
    end
  end

  // Bit counter and gathering shift register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_index     <= '0;
      gathered_bits <= '0;
    end else if (step && !exhausted) begin
      bit_index     <= bit_index_next;
      gathered_bits <= gathered_bits_next;
    end
  end

endmodule

// ===== sim/bit_plane_watermark_codec_top_test.sv =====
// ---------------------------------------------------------------------------
// Bit-plane watermark codec testbench
// Drives embed and extract items through the codec under random input gaps
// and output stalls, predicts every result item from its own copy of the
// cursor, bit counter and image size, and checks each field as it arrives.
// ---------------------------------------------------------------------------
module bit_plane_watermark_codec_top_test;

  localparam int CODEC_MAX_DIM = 4096;

  // One result item as it leaves the codec.
  typedef struct packed {
    logic [bpwm_pkg::COORD_W-1:0] pos_x;
    logic [bpwm_pkg::COORD_W-1:0] pos_y;
    logic [1:0]                   channel;
    logic [2:0]                   plane;
    logic [7:0]                   new_sample;
    logic                         byte_valid;
    logic [7:0]                   byte_out;
    logic                         overrun;
    logic [bpwm_pkg::COORD_W-1:0] next_x;
    logic [bpwm_pkg::COORD_W-1:0] next_y;
    logic [1:0]                   next_channel;
  } codec_result_t;

  // Tracks the codec cursor and the results each accepted sample should give.
  class watermark_tracker;
    logic [bpwm_pkg::DIM_W-1:0]   width_reg;
    logic [bpwm_pkg::DIM_W-1:0]   height_reg;
    logic [bpwm_pkg::COORD_W-1:0] cur_x;
    logic [bpwm_pkg::COORD_W-1:0] cur_y;
    logic [1:0]                   cur_ch;
    logic [2:0]                   cur_plane;
    logic [2:0]                   bit_pos;
    logic [7:0]                   gathered;
    logic                         exhausted;
    codec_result_t                pending_results[$];
    int                           mismatches;
    int                           results_seen;

    function new();
      width_reg    = bpwm_pkg::WIDTH_RESET;
      height_reg   = bpwm_pkg::HEIGHT_RESET;
      cur_x        = '0;
      cur_y        = '0;
      cur_ch       = bpwm_pkg::CH_RED;
      cur_plane    = '0;
      bit_pos      = '0;
      gathered     = '0;
      exhausted    = 1'b0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_dim(logic idx, logic [bpwm_pkg::DIM_W-1:0] value);
      if (idx == bpwm_pkg::REG_IMAGE_WIDTH) width_reg = value;
      else height_reg = value;
    endfunction

    // A zero size acts as one; sizes beyond the cursor reach saturate.
    function int clamp_dim(logic [bpwm_pkg::DIM_W-1:0] v);
      int lim;
      int d;
      lim = (CODEC_MAX_DIM < bpwm_pkg::CURSOR_REACH) ? CODEC_MAX_DIM :
                                                       bpwm_pkg::CURSOR_REACH;
      d = (v == '0) ? 1 : int'(v);
      if (d > lim) d = lim;
      return d;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Works out the result of one accepted sample and moves the cursor on.
    function void predict_sample(logic req, logic [7:0] value, logic [7:0] pay);
      codec_result_t e;
      int w;
      int h;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      e = '0;
      e.pos_x      = cur_x;
      e.pos_y      = cur_y;
      e.channel    = cur_ch;
      e.plane      = cur_plane;
      e.new_sample = value;
      if (exhausted) begin
        e.overrun = 1'b1;
      end else begin
        gathered = {gathered[6:0], value[cur_plane]};
        if (req == bpwm_pkg::REQ_EMBED) e.new_sample[cur_plane] = pay[3'd7 - bit_pos];
        bit_pos = bit_pos + 3'd1;
        if (bit_pos == 3'd0) begin
          e.byte_valid = 1'b1;
          if (req == bpwm_pkg::REQ_EXTRACT) e.byte_out = gathered;
        end
        // Channel first, then column, row and plane; hold at the very end.
        if (cur_ch < bpwm_pkg::CH_BLUE) begin
          cur_ch = cur_ch + 2'd1;
        end else if (int'(cur_x) < w - 1) begin
          cur_x  = cur_x + 1'b1;
          cur_ch = bpwm_pkg::CH_RED;
        end else if (int'(cur_y) < h - 1) begin
          cur_x  = '0;
          cur_y  = cur_y + 1'b1;
          cur_ch = bpwm_pkg::CH_RED;
        end else if (cur_plane < bpwm_pkg::LAST_PLANE) begin
          cur_x     = '0;
          cur_y     = '0;
          cur_plane = cur_plane + 3'd1;
          cur_ch    = bpwm_pkg::CH_RED;
        end else begin
          exhausted = 1'b1;
        end
      end
      e.next_x       = cur_x;
      e.next_y       = cur_y;
      e.next_channel = cur_ch;
      pending_results.push_back(e);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        mismatches++;
        $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compares one result item with the oldest expectation.
    function void compare_result(codec_result_t got);
      codec_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("[%0t] unexpected result: expected none, actual x %0d y %0d",
                 $time, got.pos_x, got.pos_y);
      end else begin
        want = pending_results.pop_front();
        check_field("pos_x", 16'(want.pos_x), 16'(got.pos_x));
        check_field("pos_y", 16'(want.pos_y), 16'(got.pos_y));
        check_field("channel", 16'(want.channel), 16'(got.channel));
        check_field("plane", 16'(want.plane), 16'(got.plane));
        check_field("new_sample", 16'(want.new_sample), 16'(got.new_sample));
        check_field("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
        check_field("byte_out", 16'(want.byte_out), 16'(got.byte_out));
        check_field("overrun", 16'(want.overrun), 16'(got.overrun));
        check_field("next_x", 16'(want.next_x), 16'(got.next_x));
        check_field("next_y", 16'(want.next_y), 16'(got.next_y));
        check_field("next_channel", 16'(want.next_channel), 16'(got.next_channel));
      end
    endfunction
  endclass

  logic                         clk          = 1'b0;
  logic                         rst          = 1'b1;
  logic                         cfg_we       = 1'b0;
  logic                         cfg_index    = bpwm_pkg::REG_IMAGE_WIDTH;
  logic [bpwm_pkg::DIM_W-1:0]   cfg_data     = '0;
  logic                         in_valid     = 1'b0;
  logic                         in_stall;
  logic                         req_type     = bpwm_pkg::REQ_EXTRACT;
  logic [7:0]                   sample       = '0;
  logic [7:0]                   payload_byte = '0;
  logic                         out_valid;
  logic                         out_stall    = 1'b0;
  logic [bpwm_pkg::COORD_W-1:0] pos_x;
  logic [bpwm_pkg::COORD_W-1:0] pos_y;
  logic [1:0]                   channel;
  logic [2:0]                   plane;
  logic [7:0]                   new_sample;
  logic                         byte_valid;
  logic [7:0]                   byte_out;
  logic                         overrun;
  logic [bpwm_pkg::COORD_W-1:0] next_x;
  logic [bpwm_pkg::COORD_W-1:0] next_y;
  logic [1:0]                   next_channel;

  watermark_tracker tracker;
  codec_result_t    seen;
  bit               tx_quiet      = 1'b0;
  bit               rx_quiet      = 1'b0;
  bit               pressure_done = 1'b0;
  int               rx_hold       = 0;
  int               rx_cycle      = 0;

  bit_plane_watermark_codec_top #(
    .MAX_DIM(CODEC_MAX_DIM)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .sample(sample),
    .payload_byte(payload_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .channel(channel),
    .plane(plane),
    .new_sample(new_sample),
    .byte_valid(byte_valid),
    .byte_out(byte_out),
    .overrun(overrun),
    .next_x(next_x),
    .next_y(next_y),
    .next_channel(next_channel)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle stretches: mostly short, now and then long.
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Offers one item, waits until it is taken, then maybe leaves a gap.
  task automatic send_sample(input logic req, input logic [7:0] value,
                             input logic [7:0] pay);
    int gap;
    in_valid     <= 1'b1;
    req_type     <= req;
    sample       <= value;
    payload_byte <= pay;
    do @(posedge clk); while (in_stall);
    tracker.predict_sample(req, value, pay);
    if (!tx_quiet && $urandom_range(0, 99) < 25) begin
      gap = idle_len();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly whole bytes of one request type and one payload, some noise.
  task automatic run_random(input int count);
    logic       req;
    logic [7:0] pay;
    logic       group_req;
    logic [7:0] group_pay;
    group_req = bpwm_pkg::REQ_EXTRACT;
    group_pay = '0;
    tx_quiet  = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      if (tracker.bit_pos == 3'd0) begin
        group_req = 1'($urandom_range(0, 1));
        group_pay = 8'($urandom);
      end
      req = group_req;
      pay = group_pay;
      if ($urandom_range(0, 9) == 0) begin
        req = 1'($urandom_range(0, 1));
        pay = 8'($urandom);
      end
      send_sample(req, 8'($urandom), pay);
    end
    in_valid <= 1'b0;
  endtask

  // Writes both image size registers, width first, then height.
  task automatic write_dims(input logic [bpwm_pkg::DIM_W-1:0] w,
                            input logic [bpwm_pkg::DIM_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= bpwm_pkg::REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    tracker.set_dim(bpwm_pkg::REG_IMAGE_WIDTH, w);
    cfg_index <= bpwm_pkg::REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    tracker.set_dim(bpwm_pkg::REG_IMAGE_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drain();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Result side: check accepted items and stall at random.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen.pos_x        = pos_x;
        seen.pos_y        = pos_y;
        seen.channel      = channel;
        seen.plane        = plane;
        seen.new_sample   = new_sample;
        seen.byte_valid   = byte_valid;
        seen.byte_out     = byte_out;
        seen.overrun      = overrun;
        seen.next_x       = next_x;
        seen.next_y       = next_y;
        seen.next_channel = next_channel;
        tracker.compare_result(seen);
      end
      rx_cycle++;
      if (rx_cycle % 256 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      // One long hold-off so the codec fills up and stalls its input.
      if (!pressure_done && tracker.results_seen >= 370) begin
        pressure_done = 1'b1;
        rx_hold = 150;
        out_stall <= 1'b1;
      end else if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (!rx_quiet && $urandom_range(0, 99) < 20) begin
        rx_hold = idle_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Main sequence: directed items, then random phases over several sizes.
  initial begin
    tracker = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // A full extracted byte from alternating all-ones and all-zeros samples.
    for (int i = 0; i < 8; i++) begin
      send_sample(bpwm_pkg::REQ_EXTRACT, i[0] ? 8'h00 : 8'hFF, 8'h00);
    end
    // A full embedded byte over extreme samples.
    for (int i = 0; i < 8; i++) begin
      send_sample(bpwm_pkg::REQ_EMBED, i[0] ? 8'hFF : 8'h00, 8'hA5);
    end
    // A byte that mixes both request types, with extreme payloads.
    for (int i = 0; i < 8; i++) begin
      send_sample(i[0], 8'(i * 37), (i < 4) ? 8'hFF : 8'h00);
    end
    in_valid <= 1'b0;
    wait_drain();

    // Size extremes first: zero acts as one, oversize saturates, and the
    // cursor left beyond a shrunk size wraps as if at the last position.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_dims(13'd0, 13'h1FFF);
        1: write_dims(13'h1FFF, 13'd0);
        2: write_dims(13'd4096, 13'd4096);
        default: write_dims(13'($urandom_range(16, 8191)), 13'($urandom_range(1, 8191)));
      endcase
      run_random(140);
      wait_drain();
    end

    // Tiny images walk through every plane until the codec runs out.
    for (int ph = 0; ph < 2; ph++) begin
      write_dims(13'($urandom_range(0, 3)), 13'($urandom_range(0, 2)));
      run_random(150);
      wait_drain();
    end

    repeat (12) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #3200000;
    $display("tb: failure");
    $finish;
  end

endmodule
